FILE: hdl/sshp_pkg.sv
// Package for the SOCKS5 server handshake parser: command, route and reply codes,
// the request descriptor passed from the front end to the back end, and its expansion.
// No dependencies.
`default_nettype none

package sshp_pkg;

	localparam logic [7:0] SOCKS_VER = 8'd5;

	localparam logic [1:0] CMD_CLIENT   = 2'd0;
	localparam logic [1:0] CMD_UPSTREAM = 2'd1;
	localparam logic [1:0] CMD_CLOSE    = 2'd2;
	localparam logic [1:0] CMD_NONE     = 2'd3;

	localparam logic [1:0] ROUTE_CLIENT   = 2'd0;
	localparam logic [1:0] ROUTE_TARGET   = 2'd1;
	localparam logic [1:0] ROUTE_UPSTREAM = 2'd2;
	localparam logic [1:0] ROUTE_CLOSE    = 2'd3;

	localparam logic [1:0] KIND_SINGLE = 2'd0;
	localparam logic [1:0] KIND_GREET  = 2'd1;
	localparam logic [1:0] KIND_TYPE   = 2'd2;
	localparam logic [1:0] KIND_ECHO   = 2'd3;

	localparam logic [7:0] REP_OK       = 8'd0;
	localparam logic [7:0] REP_BAD_CMD  = 8'd7;
	localparam logic [7:0] REP_BAD_ATYP = 8'd8;

	localparam logic [7:0] METHOD_NOAUTH = 8'h00;
	localparam logic [7:0] METHOD_NONE   = 8'hFF;
	localparam logic [7:0] CMD_CONNECT   = 8'd1;

	localparam logic [7:0] ATYP_IPV4   = 8'd1;
	localparam logic [7:0] ATYP_DOMAIN = 8'd3;
	localparam logic [7:0] ATYP_IPV6   = 8'd4;

	localparam logic [8:0] ECHO_IPV4       = 9'd6;
	localparam logic [8:0] ECHO_IPV6       = 9'd18;
	localparam logic [8:0] ECHO_DOMAIN_LEN = 9'd1;
	localparam logic [8:0] ECHO_DOMAIN_ADD = 9'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] route;
		logic [7:0] data;
		logic [7:0] aux;
		logic       last;
		logic       good;
		logic       close_after;
	} desc_t;

	typedef struct packed {
		logic [1:0] route;
		logic [7:0] data;
		logic       last;
	} item_t;

	function automatic logic [2:0] desc_items(desc_t d);
		logic [2:0] n;
		unique case (d.kind)
			KIND_SINGLE: n = 3'd1;
			KIND_GREET:  n = 3'd2;
			KIND_TYPE:   n = 3'd4 + {2'b00, d.good};
			default:     n = 3'd1 + {2'b00, d.good} + {2'b00, d.close_after};
		endcase
		return n;
	endfunction

	function automatic item_t desc_item(desc_t d, logic [2:0] idx);
		item_t it;
		unique case (d.kind)
			KIND_SINGLE: it = '{route: d.route, data: d.data, last: d.last};
			KIND_GREET: begin
				if (idx == 3'd0)
					it = '{route: ROUTE_CLIENT, data: SOCKS_VER, last: 1'b0};
				else
					it = '{route: ROUTE_CLIENT, data: d.data, last: 1'b1};
			end
			KIND_TYPE: begin
				unique case (idx)
					3'd0: it = '{route: ROUTE_CLIENT, data: SOCKS_VER, last: 1'b0};
					3'd1: it = '{route: ROUTE_CLIENT, data: d.aux, last: 1'b0};
					3'd2: it = '{route: ROUTE_CLIENT, data: 8'd0, last: 1'b0};
					3'd3: it = '{route: ROUTE_CLIENT, data: d.data, last: 1'b0};
					default: it = '{route: ROUTE_TARGET, data: d.data, last: 1'b0};
				endcase
			end
			default: begin
				if (idx == 3'd0)
					it = '{route: ROUTE_CLIENT, data: d.data, last: d.last};
				else if (idx == 3'd1 && d.good)
					it = '{route: ROUTE_TARGET, data: d.data, last: d.last};
				else
					it = '{route: ROUTE_CLOSE, data: 8'd0, last: 1'b0};
			end
		endcase
		return it;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/sshp_in_if.sv
// Input channel of the SOCKS5 server handshake parser: one byte or event per transfer.
// No dependencies.
`default_nettype none

interface sshp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_byte;

	modport source (output valid, command, data_byte, input ready);
	modport sink (input valid, command, data_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/sshp_out_if.sv
// Output channel of the SOCKS5 server handshake parser: one routed byte per transfer.
// No dependencies.
`default_nettype none

interface sshp_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] route;
	logic [7:0] out_byte;
	logic       run_last;

	modport source (output valid, route, out_byte, run_last, input ready);
	modport sink (input valid, route, out_byte, run_last, output ready);
endinterface

`default_nettype wire

FILE: hdl/sshp_front.sv
// Front end: accepts input items, tracks the session phase and turns each item
// into at most one request descriptor. Depends on sshp_pkg and sshp_in_if.
`default_nettype none

module sshp_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	sshp_in_if.sink              inbound,
	input  wire logic            full,
	output logic                 push,
	output sshp_pkg::desc_t      push_desc
);
	import sshp_pkg::*;

	localparam logic [2:0] PH_VER     = 3'd0;
	localparam logic [2:0] PH_NMETH   = 3'd1;
	localparam logic [2:0] PH_METHODS = 3'd2;
	localparam logic [2:0] PH_REQUEST = 3'd3;
	localparam logic [2:0] PH_ECHO    = 3'd4;
	localparam logic [2:0] PH_RELAY   = 3'd5;
	localparam logic [2:0] PH_CLOSED  = 3'd6;

	logic [2:0] phase_q, phase_d;
	logic [7:0] methods_left_q, methods_left_d;
	logic       noauth_q, noauth_d;
	logic [1:0] req_pos_q, req_pos_d;
	logic       ver_ok_q, ver_ok_d;
	logic       cmd_ok_q, cmd_ok_d;
	logic       good_q, good_d;
	logic [8:0] echo_left_q, echo_left_d;
	logic       dom_pend_q, dom_pend_d;

	logic       accept;
	logic [1:0] cmd;
	logic [7:0] b;
	logic [8:0] el;
	logic [8:0] el_next;
	logic [7:0] ml_next;
	logic       ns_next;
	logic [7:0] code;

	assign inbound.ready = !full;
	assign accept = inbound.valid && inbound.ready;
	assign cmd = inbound.command;
	assign b = inbound.data_byte;

	always_comb begin
		phase_d = phase_q;
		methods_left_d = methods_left_q;
		noauth_d = noauth_q;
		req_pos_d = req_pos_q;
		ver_ok_d = ver_ok_q;
		cmd_ok_d = cmd_ok_q;
		good_d = good_q;
		echo_left_d = echo_left_q;
		dom_pend_d = dom_pend_q;
		push = 1'b0;
		push_desc = '0;
		el = dom_pend_q ? ({1'b0, b} + ECHO_DOMAIN_ADD) : echo_left_q;
		el_next = (el != 9'd0) ? (el - 9'd1) : 9'd0;
		ml_next = (methods_left_q != 8'd0) ? (methods_left_q - 8'd1) : 8'd0;
		ns_next = noauth_q || (b == METHOD_NOAUTH);
		code = REP_OK;

		if (accept && phase_q != PH_CLOSED && cmd != CMD_NONE) begin
			priority if (cmd == CMD_CLOSE) begin
				push = 1'b1;
				push_desc.kind = KIND_SINGLE;
				push_desc.route = ROUTE_CLOSE;
				phase_d = PH_CLOSED;
			end else if (cmd == CMD_UPSTREAM) begin
				if (phase_q == PH_RELAY) begin
					push = 1'b1;
					push_desc.kind = KIND_SINGLE;
					push_desc.route = ROUTE_CLIENT;
					push_desc.data = b;
				end
			end else begin
				unique case (phase_q)
					PH_VER: begin
						if (b != SOCKS_VER) begin
							push = 1'b1;
							push_desc.kind = KIND_SINGLE;
							push_desc.route = ROUTE_CLOSE;
							phase_d = PH_CLOSED;
						end else begin
							phase_d = PH_NMETH;
						end
					end
					PH_NMETH: begin
						methods_left_d = b;
						noauth_d = 1'b0;
						if (b == 8'd0) begin
							push = 1'b1;
							push_desc.kind = KIND_GREET;
							push_desc.data = METHOD_NONE;
							phase_d = PH_REQUEST;
							req_pos_d = 2'd0;
						end else begin
							phase_d = PH_METHODS;
						end
					end
					PH_METHODS: begin
						noauth_d = ns_next;
						methods_left_d = ml_next;
						if (ml_next == 8'd0) begin
							push = 1'b1;
							push_desc.kind = KIND_GREET;
							push_desc.data = ns_next ? METHOD_NOAUTH : METHOD_NONE;
							phase_d = PH_REQUEST;
							req_pos_d = 2'd0;
						end
					end
					PH_REQUEST: begin
						unique case (req_pos_q)
							2'd0: begin
								ver_ok_d = (b == SOCKS_VER);
								req_pos_d = 2'd1;
							end
							2'd1: begin
								cmd_ok_d = (b == CMD_CONNECT);
								req_pos_d = 2'd2;
							end
							2'd2: req_pos_d = 2'd3;
							default: begin
								req_pos_d = 2'd0;
								dom_pend_d = 1'b0;
								echo_left_d = ECHO_IPV4;
								priority if (!ver_ok_q || !cmd_ok_q) begin
									code = REP_BAD_CMD;
								end else if (b == ATYP_IPV4) begin
									echo_left_d = ECHO_IPV4;
								end else if (b == ATYP_IPV6) begin
									echo_left_d = ECHO_IPV6;
								end else if (b == ATYP_DOMAIN) begin
									dom_pend_d = 1'b1;
									echo_left_d = ECHO_DOMAIN_LEN;
								end else begin
									code = REP_BAD_ATYP;
								end
								good_d = (code == REP_OK);
								push = 1'b1;
								push_desc.kind = KIND_TYPE;
								push_desc.data = b;
								push_desc.aux = code;
								push_desc.good = (code == REP_OK);
								phase_d = PH_ECHO;
							end
						endcase
					end
					PH_ECHO: begin
						dom_pend_d = 1'b0;
						echo_left_d = el_next;
						push = 1'b1;
						push_desc.kind = KIND_ECHO;
						push_desc.data = b;
						push_desc.last = (el == 9'd1);
						push_desc.good = good_q;
						if (el_next == 9'd0) begin
							push_desc.close_after = !good_q;
							phase_d = good_q ? PH_RELAY : PH_CLOSED;
						end
					end
					PH_RELAY: begin
						push = 1'b1;
						push_desc.kind = KIND_SINGLE;
						push_desc.route = ROUTE_UPSTREAM;
						push_desc.data = b;
					end
					default: phase_d = PH_CLOSED;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VER;
			methods_left_q <= 8'd0;
			noauth_q <= 1'b0;
			req_pos_q <= 2'd0;
			ver_ok_q <= 1'b0;
			cmd_ok_q <= 1'b0;
			good_q <= 1'b0;
			echo_left_q <= 9'd0;
			dom_pend_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			methods_left_q <= methods_left_d;
			noauth_q <= noauth_d;
			req_pos_q <= req_pos_d;
			ver_ok_q <= ver_ok_d;
			cmd_ok_q <= cmd_ok_d;
			good_q <= good_d;
			echo_left_q <= echo_left_d;
			dom_pend_q <= dom_pend_d;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/sshp_queue.sv
// Small first-in first-out queue of request descriptors between front and back end.
// Generic in width and depth; no dependencies.
`default_nettype none

module sshp_queue #(
	parameter int WIDTH = 23,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : (wr_ptr_q + PW'(1));
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : (rd_ptr_q + PW'(1));
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

FILE: hdl/sshp_back.sv
// Back end: expands each request descriptor into its result bytes, one per cycle while
// the output is not stalled, into the output register. Depends on sshp_pkg and sshp_out_if.
`default_nettype none

module sshp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sshp_pkg::desc_t  head,
	input  wire logic             head_valid,
	output logic                  pop,
	sshp_out_if.source            outbound
);
	import sshp_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	item_t      out_item_q;
	item_t      cur;
	logic [2:0] count;
	logic       load;
	logic       final_item;

	assign cur = desc_item(head, idx_q);
	assign count = desc_items(head);
	assign final_item = (idx_q == (count - 3'd1));
	assign load = head_valid && (!out_valid_q || outbound.ready);
	assign pop = load && final_item;

	assign outbound.valid = out_valid_q;
	assign outbound.route = out_item_q.route;
	assign outbound.out_byte = out_item_q.data;
	assign outbound.run_last = out_item_q.last;

	always_ff @(posedge clk) begin
		if (load)
			out_item_q <= cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= final_item ? 3'd0 : (idx_q + 3'd1);
			if (load)
				out_valid_q <= 1'b1;
			else if (outbound.ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/socks5_server_handshake_parser.sv
// Top level of the SOCKS5 server handshake parser: front end, descriptor queue, back end.
// Depends on sshp_pkg, sshp_in_if, sshp_out_if, sshp_front, sshp_queue and sshp_back.
//
//   Channel    Direction  Payload                          Handshake
//   inbound    in         command[1:0], data_byte[7:0]     valid/ready
//   outbound   out        route[1:0], out_byte[7:0], run_last  valid/ready
//
// A byte or event is classified in the cycle it is accepted; each request yields
// at most one descriptor, and the back end issues one result per cycle from it
// while outbound is ready. Relay bytes likewise pass at one per cycle; a greeting
// reply is two result bytes, a request type byte four or five, an echo byte up to two.
// Reset leaves the session awaiting the greeting version with an empty queue.
// Input stalls only when the QUEUE_DEPTH-entry queue is full.
`default_nettype none

module socks5_server_handshake_parser #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sshp_in_if.sink    inbound,
	sshp_out_if.source outbound
);
	import sshp_pkg::*;

	logic  q_push;
	logic  q_pop;
	logic  q_full;
	logic  q_empty;
	desc_t push_desc;
	desc_t head_desc;

	sshp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.inbound   (inbound),
		.full      (q_full),
		.push      (q_push),
		.push_desc (push_desc)
	);

	sshp_queue #(
		.WIDTH ($bits(desc_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_desc),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (head_desc),
		.empty  (q_empty)
	);

	sshp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_desc),
		.head_valid (!q_empty),
		.pop        (q_pop),
		.outbound   (outbound)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("descriptor pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("descriptor popped from an empty queue");

	a_close_is_bare: assert property (@(posedge clk) disable iff (!arst_n)
		(outbound.valid && outbound.route == ROUTE_CLOSE)
			|-> (outbound.out_byte == 8'd0 && !outbound.run_last))
		else $error("close result carries a byte or a run end");

endmodule

`default_nettype wire
